>>> hw/rtl/delta_zigzag_packed_decoder_unit_macros.svh
// ---------------------------------------------------------------------------
// Delta zigzag packed decoder: assertion macros
// Clocked property checks that drop to nothing when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef DELTA_ZIGZAG_PACKED_DECODER_UNIT_MACROS_SVH
`define DELTA_ZIGZAG_PACKED_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define DZZ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define DZZ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define DZZ_ASSERT(label, clk, rst_n, prop, msg)

`define DZZ_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> hw/rtl/dzz_pkg.sv
// ---------------------------------------------------------------------------
// Delta zigzag packed decoder: package
// Widths, byte form codes, decoder state and result types, zigzag helper.
// ---------------------------------------------------------------------------
package dzz_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 32;
    localparam int LINE_W   = 16;
    localparam int LEN_W    = LINE_W + 1;
    localparam int SHIFT_W  = 6;
    localparam int SLOT_W   = 2;

    localparam logic [LINE_W-1:0]  DEFAULT_SAMPLES_PER_LINE = 16'd4096;
    localparam logic [LEN_W-1:0]   LINE_MAX    = {1'b1, {LINE_W{1'b0}}};
    localparam logic [LEN_W-1:0]   TRIPLE_COUNT = 17'd3;
    localparam logic [LEN_W-1:0]   PAIR_COUNT   = 17'd2;

    localparam int                 CONT_MORE_BIT = 7;
    localparam logic [SHIFT_W-1:0] HEAD_SHIFT    = 6'd6;
    localparam logic [SHIFT_W-1:0] CONT_STEP     = 6'd7;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT   = 6'd32;

    localparam logic [SLOT_W-1:0]  SLOT_FIRST  = 2'd0;
    localparam logic [SLOT_W-1:0]  SLOT_SECOND = 2'd1;
    localparam logic [SLOT_W-1:0]  SLOT_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        FORM_TRIPLE = 2'b00,
        FORM_PAIR   = 2'b01,
        FORM_SINGLE = 2'b10,
        FORM_LONG   = 2'b11
    } form_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] running_value;
        logic [LINE_W-1:0]   samples_done;
        logic                in_long_code;
        logic [SAMPLE_W-1:0] long_code_value;
        logic [SHIFT_W-1:0]  long_code_shift;
    } dec_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       line_end;
        logic                       error;
        logic                       run_last;
    } result_t;

    function automatic logic [SAMPLE_W-1:0] zigzag_decode(input logic [SAMPLE_W-1:0] code);
        logic [SAMPLE_W-1:0] half;
        half = code >> 1;
        return code[0] ? ~half : half;
    endfunction

endpackage

>>> hw/rtl/dzz_step.sv
// ---------------------------------------------------------------------------
// Delta zigzag packed decoder: decode step
// Decodes one code slot of the held byte, applies it to the running sample
// and gives the next decoder state.
// ---------------------------------------------------------------------------
module dzz_step (
    input  dzz_pkg::dec_state_t         cur_state,
    input  logic [dzz_pkg::BYTE_W-1:0]  code_byte,
    input  logic [dzz_pkg::SLOT_W-1:0]  slot,
    input  logic [dzz_pkg::LINE_W-1:0]  samples_per_line,
    output dzz_pkg::dec_state_t         next_state,
    output dzz_pkg::result_t            result,
    output logic                        emit,
    output logic                        last
);
    import dzz_pkg::*;

    logic [LEN_W-1:0]    line_len;
    logic [LEN_W-1:0]    done_ext;
    logic [LEN_W-1:0]    done_inc;
    logic                line_done;
    logic                overrun;
    logic [SAMPLE_W-1:0] acc;
    logic [SHIFT_W-1:0]  new_shift;
    logic [SAMPLE_W-1:0] code;
    logic [SAMPLE_W-1:0] sum;

    assign line_len  = (samples_per_line == '0) ? LINE_MAX : {1'b0, samples_per_line};
    assign done_ext  = {1'b0, cur_state.samples_done};
    assign done_inc  = done_ext + LEN_W'(1);
    assign line_done = (done_inc >= line_len);

    always_comb begin
        next_state = cur_state;
        result     = '0;
        emit       = 1'b0;
        last       = 1'b1;
        overrun    = 1'b0;
        code       = '0;
        acc        = cur_state.long_code_value;
        new_shift  = cur_state.long_code_shift;

        if (cur_state.long_code_shift < SHIFT_LIMIT) begin
            acc       = acc | (SAMPLE_W'(code_byte[6:0]) << cur_state.long_code_shift[4:0]);
            new_shift = cur_state.long_code_shift + CONT_STEP;
        end

        if (cur_state.in_long_code) begin
            if (code_byte[CONT_MORE_BIT]) begin
                next_state.long_code_value = acc;
                next_state.long_code_shift = new_shift;
            end else begin
                emit = 1'b1;
                code = acc;
                next_state.in_long_code    = 1'b0;
                next_state.long_code_value = '0;
                next_state.long_code_shift = '0;
            end
        end else begin
            case (form_t'(code_byte[7:6]))
                FORM_TRIPLE: begin
                    emit    = 1'b1;
                    overrun = (slot == SLOT_FIRST) && (done_ext + TRIPLE_COUNT > line_len);
                    case (slot)
                        SLOT_FIRST: begin
                            code = SAMPLE_W'(code_byte[1:0]);
                            last = 1'b0;
                        end
                        SLOT_SECOND: begin
                            code = SAMPLE_W'(code_byte[3:2]);
                            last = 1'b0;
                        end
                        default: begin
                            code = SAMPLE_W'(code_byte[5:4]);
                        end
                    endcase
                end
                FORM_PAIR: begin
                    emit    = 1'b1;
                    overrun = (slot == SLOT_FIRST) && (done_ext + PAIR_COUNT > line_len);
                    case (slot)
                        SLOT_FIRST: begin
                            code = SAMPLE_W'(code_byte[2:0]);
                            last = 1'b0;
                        end
                        default: begin
                            code = SAMPLE_W'(code_byte[5:3]);
                        end
                    endcase
                end
                FORM_SINGLE: begin
                    emit = 1'b1;
                    code = SAMPLE_W'(code_byte[5:0]);
                end
                FORM_LONG: begin
                    next_state.in_long_code    = 1'b1;
                    next_state.long_code_value = SAMPLE_W'(code_byte[5:0]);
                    next_state.long_code_shift = HEAD_SHIFT;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        sum = cur_state.running_value + zigzag_decode(code);

        if (overrun) begin
            last                     = 1'b1;
            result.error             = 1'b1;
            result.run_last          = 1'b1;
            next_state.running_value = '0;
            next_state.samples_done  = '0;
        end else if (emit) begin
            result.sample            = sum;
            result.line_end          = line_done;
            result.run_last          = last;
            next_state.running_value = line_done ? '0 : sum;
            next_state.samples_done  = line_done ? '0 : done_inc[LINE_W-1:0];
        end
    end

endmodule

>>> hw/rtl/dzz_out_stage.sv
// ---------------------------------------------------------------------------
// Delta zigzag packed decoder: result register
// Holds one result for the result channel and frees itself on transfer.
// ---------------------------------------------------------------------------
module dzz_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  dzz_pkg::result_t                    result,
    output logic                                can_load,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dzz_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                m_line_end,
    output logic                                m_error,
    output logic                                m_run_last
);
    import dzz_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid    = valid_reg;
    assign m_sample   = data_reg.sample;
    assign m_line_end = data_reg.line_end;
    assign m_error    = data_reg.error;
    assign m_run_last = data_reg.run_last;

endmodule

>>> hw/rtl/delta_zigzag_packed_decoder_unit.sv
// ---------------------------------------------------------------------------
// Delta zigzag packed decoder unit
// Rebuilds 32-bit samples from a byte stream of packed and long zigzag codes.
// ---------------------------------------------------------------------------
// Input channel s_*: one compressed byte per transfer. Result channel m_*:
// one sample per transfer, with line_end, error and run_last flags.
// cfg_wr_en/cfg_wr_data write the line length (samples per line, 0 = 65536)
// and take effect on the next byte; write only while the unit is idle.
// A byte is held in an input register; one code slot of it is decoded per
// cycle while the output register can take its result, and any result is
// written to the output register, from which the result channel reads.
// A byte yields three 2-bit codes, two 3-bit codes or a single code, each
// decoded in its own slot; an overrun error, a long head or a continuation
// byte takes a single slot. The next byte is taken in the cycle its
// predecessor's last slot advances, so the input register refills as it
// empties. A stalled receiver holds the output register and, through it,
// any slot with a result to load and the input register; nothing is dropped.
// Reset clears the running sample, the line count and any partial long code,
// and sets the line length to 4096.
// ---------------------------------------------------------------------------
`include "delta_zigzag_packed_decoder_unit_macros.svh"

module delta_zigzag_packed_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dzz_pkg::LINE_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dzz_pkg::BYTE_W-1:0]          s_code_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dzz_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                m_line_end,
    output logic                                m_error,
    output logic                                m_run_last
);
    import dzz_pkg::*;

    logic [LINE_W-1:0] spl_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              byte_vld_reg;
    logic              byte_vld_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    dec_state_t        state_reg;
    dec_state_t        state_next;

    dec_state_t        step_state;
    result_t           step_result;
    logic              step_emit;
    logic              step_last;
    logic              can_load;
    logic              advance;
    logic              byte_done;

    dzz_step u_step (
        .cur_state        (state_reg),
        .code_byte        (byte_reg),
        .slot             (slot_reg),
        .samples_per_line (spl_reg),
        .next_state       (step_state),
        .result           (step_result),
        .emit             (step_emit),
        .last             (step_last)
    );

    dzz_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && step_emit),
        .result     (step_result),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (m_sample),
        .m_line_end (m_line_end),
        .m_error    (m_error),
        .m_run_last (m_run_last)
    );

    assign advance   = byte_vld_reg && (!step_emit || can_load);
    assign byte_done = advance && step_last;
    assign s_ready   = !byte_vld_reg || byte_done;

    always_comb begin
        state_next    = advance ? step_state : state_reg;
        slot_next     = slot_reg;
        byte_vld_next = byte_vld_reg;
        if (advance) begin
            slot_next = step_last ? SLOT_FIRST : slot_reg + SLOT_W'(1);
        end
        if (s_valid && s_ready) begin
            byte_vld_next = 1'b1;
        end else if (byte_done) begin
            byte_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spl_reg      <= DEFAULT_SAMPLES_PER_LINE;
            byte_vld_reg <= 1'b0;
            slot_reg     <= SLOT_FIRST;
            state_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                spl_reg <= cfg_wr_data;
            end
            byte_vld_reg <= byte_vld_next;
            slot_reg     <= slot_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_code_byte;
        end
    end

    `DZZ_ASSERT_NEVER(a_slot_range, aclk, aresetn, slot_reg > SLOT_THIRD, "slot out of range")

    `DZZ_ASSERT(a_slot_needs_packed, aclk, aresetn,
        (slot_reg != SLOT_FIRST) |-> (byte_vld_reg && !state_reg.in_long_code),
        "mid-byte slot without a held packed byte")

    `DZZ_ASSERT(a_long_idle_clear, aclk, aresetn,
        !state_reg.in_long_code |->
            (state_reg.long_code_value == '0 && state_reg.long_code_shift == '0),
        "long code state left over")

    `DZZ_ASSERT(a_error_shape, aclk, aresetn,
        (m_valid && m_error) |-> (m_sample == '0 && m_run_last && !m_line_end),
        "malformed error result")

    `DZZ_ASSERT(a_error_restarts, aclk, aresetn,
        (advance && step_emit && step_result.error) |=>
            (state_reg.running_value == '0 && state_reg.samples_done == '0
             && slot_reg == SLOT_FIRST),
        "overrun did not restart the line")

endmodule
